>>> design/qsn_pkg.sv
// shared constants, tables and types for the quaternion slerp pipeline
// no dependencies; imported by qsn_sqrt, qsn_div, quaternion_slerp_normalized and the bench
package qsn_pkg;

  localparam int STEPS  = 31;
  localparam int ROOT_W = 32;
  localparam int QUOT_W = 32;
  localparam int VW     = 34;

  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] GAIN_Q30    = 31'd652032874;
  localparam logic [30:0] SIN_EPS_Q30 = 31'd1074;
  localparam logic [60:0] TWO_POW_60  = 61'h1000_0000_0000_0000;
  localparam logic [14:0] T_ONE       = 15'd16384;

  localparam logic [30:0] ARC_TAB [STEPS] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
    31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
    31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
    31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1
  };

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;
    logic [30:0]      t30;
    logic [30:0]      dot;
    logic             near_par;
  } side_t;

  typedef logic [3:0][32:0] cvec_t;

  typedef struct packed {
    logic [3:0] neg;
    logic       zero;
  } fin_t;

endpackage

>>> design/qsn_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on qsn_pkg
module qsn_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [2*qsn_pkg::ROOT_W-1:0]  rad,
  output logic                          out_valid,
  output logic [qsn_pkg::ROOT_W-1:0]    root
);
  import qsn_pkg::*;

  localparam int RW = 2 * ROOT_W;

  logic [ROOT_W+1:0] rem [0:ROOT_W];
  logic [RW-1:0]     rd  [0:ROOT_W];
  logic [ROOT_W-1:0] rt  [0:ROOT_W];
  logic              vl  [0:ROOT_W];

  assign rem[0] = '0;
  assign rd[0]  = rad;
  assign rt[0]  = '0;
  assign vl[0]  = in_valid;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic [ROOT_W+3:0] tr, trial, diff;
    logic              ge;

    assign tr    = {rem[i], rd[i][RW-1 -: 2]};
    assign trial = {2'b00, rt[i], 2'b01};
    assign diff  = tr - trial;
    assign ge    = tr >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? diff[ROOT_W+1:0] : tr[ROOT_W+1:0];
      rt[i+1]  <= {rt[i][ROOT_W-2:0], ge};
      rd[i+1]  <= {rd[i][RW-3:0], 2'b00};
    end
  end

  assign out_valid = vl[ROOT_W];
  assign root      = rt[ROOT_W];

endmodule

>>> design/qsn_div.sv
// pipelined restoring divider, one quotient bit per stage
// numerator is {num_hi, num_lo} with num_hi below den; depends on qsn_pkg
module qsn_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [qsn_pkg::QUOT_W-1:0]  num_hi,
  input  logic [qsn_pkg::QUOT_W-1:0]  num_lo,
  input  logic [qsn_pkg::QUOT_W-1:0]  den,
  output logic                        out_valid,
  output logic [qsn_pkg::QUOT_W-1:0]  quot
);
  import qsn_pkg::*;

  logic [QUOT_W-1:0] rem [0:QUOT_W];
  logic [QUOT_W-1:0] lo  [0:QUOT_W];
  logic [QUOT_W-1:0] qt  [0:QUOT_W];
  logic [QUOT_W-1:0] dv  [0:QUOT_W];
  logic              vl  [0:QUOT_W];

  assign rem[0] = num_hi;
  assign lo[0]  = num_lo;
  assign qt[0]  = '0;
  assign dv[0]  = den;
  assign vl[0]  = in_valid;

  for (genvar i = 0; i < QUOT_W; i++) begin : g_step
    logic [QUOT_W:0] tr, diff;
    logic            ge;

    assign tr   = {rem[i], lo[i][QUOT_W-1]};
    assign diff = tr - {1'b0, dv[i]};
    assign ge   = tr >= {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? diff[QUOT_W-1:0] : tr[QUOT_W-1:0];
      lo[i+1]  <= {lo[i][QUOT_W-2:0], 1'b0};
      qt[i+1]  <= {qt[i][QUOT_W-2:0], ge};
      dv[i+1]  <= dv[i];
    end
  end

  assign out_valid = vl[QUOT_W];
  assign quot      = qt[QUOT_W];

endmodule

>>> design/quaternion_slerp_normalized.sv
// quaternion slerp with normalised result, fully pipelined fixed point
// depends on qsn_pkg, qsn_sqrt and qsn_div
//
//   channel   handshake      payload
//   input     start / busy   a_x a_y a_z a_w b_x b_y b_z b_w weight
//   result    done           out_x out_y out_z out_w
//
// one item may be started every cycle; busy is held low
// done pulses once per item after the transfer edge, set by the chain of
// square root (32), cordic (31 + 31), divider (32) stages, twice for root and divide
// synchronous reset clears only the valid bits of the pipeline
// the receiver cannot stall, so the pipeline advances every cycle
module quaternion_slerp_normalized (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] a_x,
  input  logic signed [15:0] a_y,
  input  logic signed [15:0] a_z,
  input  logic signed [15:0] a_w,
  input  logic signed [15:0] b_x,
  input  logic signed [15:0] b_y,
  input  logic signed [15:0] b_z,
  input  logic signed [15:0] b_w,
  input  logic signed [15:0] weight,
  output logic               done,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w
);
  import qsn_pkg::*;

  assign busy = 1'b0;

  // stage 0: capture, clamp weight
  logic               v0;
  logic signed [15:0] a0 [4];
  logic signed [15:0] b0 [4];
  logic [30:0]        t30_0;
  logic [14:0]        tcl;

  always_comb begin
    if (weight[15]) begin
      tcl = '0;
    end else if (weight[14:0] > T_ONE) begin
      tcl = T_ONE;
    end else begin
      tcl = weight[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a0    <= '{a_x, a_y, a_z, a_w};
    b0    <= '{b_x, b_y, b_z, b_w};
    t30_0 <= {tcl, 16'b0};
  end

  // stage 1: products for the dot
  logic               v1;
  logic signed [31:0] p1 [4];
  logic signed [15:0] a1 [4];
  logic signed [15:0] b1 [4];
  logic [30:0]        t30_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      p1[k] <= a0[k] * b0[k];
    end
    a1    <= a0;
    b1    <= b0;
    t30_1 <= t30_0;
  end

  // stage 2: dot sum, shorter arc, clamp
  logic               v2;
  side_t              side2;
  logic signed [33:0] dsum, dabs;
  logic               dneg;
  side_t              side2_next;

  always_comb begin
    dsum = 34'(p1[0]) + 34'(p1[1]) + 34'(p1[2]) + 34'(p1[3]);
    dneg = dsum[33];
    dabs = dneg ? -dsum : dsum;
    side2_next = '0;
    for (int k = 0; k < 4; k++) begin
      side2_next.a[k] = a1[k];
      side2_next.b[k] = dneg ? -17'(b1[k]) : 17'(b1[k]);
    end
    side2_next.t30 = t30_1;
    // dot is four times the sum
    if (dabs > 34'sd268435456) begin
      side2_next.dot = ONE_Q30;
    end else begin
      side2_next.dot = {dabs[28:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    side2 <= side2_next;
  end

  // stage 3: dot squared
  logic        v3;
  side_t       side3;
  logic [61:0] sq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sq3   <= side2.dot * side2.dot;
    side3 <= side2;
  end

  // stage 4: radicand for sin theta
  logic        v4;
  logic [63:0] rad4;
  side_t       sd1 [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    rad4   <= {3'b000, TWO_POW_60 - sq3[60:0]};
    sd1[0] <= side3;
  end

  logic              r1_v;
  logic [ROOT_W-1:0] r1_q;

  qsn_sqrt u_root_sin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .rad       (rad4),
    .out_valid (r1_v),
    .root      (r1_q)
  );

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sd1
    always_ff @(posedge clk) begin
      sd1[i+1] <= sd1[i];
    end
  end

  // vectoring cordic for theta
  logic signed [VW-1:0] cx  [0:STEPS];
  logic signed [VW-1:0] cy  [0:STEPS];
  logic signed [VW-1:0] cz  [0:STEPS];
  logic                 cv  [0:STEPS];
  side_t                cs  [0:STEPS];
  logic [30:0]          csn [0:STEPS];
  side_t                side5;

  always_comb begin
    side5 = sd1[ROOT_W];
    side5.near_par = r1_q < 32'(SIN_EPS_Q30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= r1_v;
    end
  end

  always_ff @(posedge clk) begin
    cx[0]  <= $signed({{(VW-31){1'b0}}, sd1[ROOT_W].dot});
    cy[0]  <= $signed({{(VW-ROOT_W){1'b0}}, r1_q});
    cz[0]  <= '0;
    cs[0]  <= side5;
    csn[0] <= r1_q[30:0];
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    logic signed [VW-1:0] arc;
    assign arc = $signed({{(VW-31){1'b0}}, ARC_TAB[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!cy[i][VW-1] && cy[i] != '0) begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + arc;
      end else begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - arc;
      end
      cs[i+1]  <= cs[i];
      csn[i+1] <= csn[i];
    end
  end

  // stage 6: clamp theta to the first quadrant
  logic        v6;
  logic [30:0] th6;
  side_t       side6;
  logic [30:0] sinth6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= cv[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (cz[STEPS][VW-1]) begin
      th6 <= '0;
    end else if (cz[STEPS] > $signed({{(VW-31){1'b0}}, HALF_PI_Q30})) begin
      th6 <= HALF_PI_Q30;
    end else begin
      th6 <= cz[STEPS][30:0];
    end
    side6  <= cs[STEPS];
    sinth6 <= csn[STEPS];
  end

  // rotation cordic, two lanes for the two angles
  logic signed [VW-1:0] rx  [0:STEPS][0:1];
  logic signed [VW-1:0] ry  [0:STEPS][0:1];
  logic signed [VW-1:0] rz  [0:STEPS][0:1];
  logic                 rv  [0:STEPS];
  side_t                rs  [0:STEPS];
  logic [30:0]          rsn [0:STEPS];
  logic [61:0]          pr  [2];

  always_comb begin
    pr[0] = (ONE_Q30 - side6.t30) * th6;
    pr[1] = side6.t30 * th6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else begin
      rv[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      rx[0][l] <= $signed({{(VW-31){1'b0}}, GAIN_Q30});
      ry[0][l] <= '0;
      rz[0][l] <= $signed({{(VW-31){1'b0}}, pr[l][60:30]});
    end
    rs[0]  <= side6;
    rsn[0] <= sinth6;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [VW-1:0] arc;
    assign arc = $signed({{(VW-31){1'b0}}, ARC_TAB[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[i+1] <= 1'b0;
      end else begin
        rv[i+1] <= rv[i];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 2; l++) begin
        if (!rz[i][l][VW-1]) begin
          rx[i+1][l] <= rx[i][l] - (ry[i][l] >>> i);
          ry[i+1][l] <= ry[i][l] + (rx[i][l] >>> i);
          rz[i+1][l] <= rz[i][l] - arc;
        end else begin
          rx[i+1][l] <= rx[i][l] + (ry[i][l] >>> i);
          ry[i+1][l] <= ry[i][l] - (rx[i][l] >>> i);
          rz[i+1][l] <= rz[i][l] + arc;
        end
      end
      rs[i+1]  <= rs[i];
      rsn[i+1] <= rsn[i];
    end
  end

  // stage 8: clamp sines to [0, 1]
  logic        v8;
  logic [30:0] s8 [2];
  logic [30:0] sinth8;
  side_t       sd2 [0:QUOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= rv[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (ry[STEPS][l][VW-1]) begin
        s8[l] <= '0;
      end else if (ry[STEPS][l] > $signed({{(VW-31){1'b0}}, ONE_Q30})) begin
        s8[l] <= ONE_Q30;
      end else begin
        s8[l] <= ry[STEPS][l][30:0];
      end
    end
    sinth8 <= rsn[STEPS];
    sd2[0] <= rs[STEPS];
  end

  logic [1:0]        wq_v;
  logic [QUOT_W-1:0] wq [2];

  for (genvar l = 0; l < 2; l++) begin : g_wdiv
    qsn_div u_wdiv (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v8),
      .num_hi    ({3'b000, s8[l][30:2]}),
      .num_lo    ({s8[l][1:0], 30'b0}),
      .den       ({1'b0, sinth8}),
      .out_valid (wq_v[l]),
      .quot      (wq[l])
    );
  end

  for (genvar i = 0; i < QUOT_W; i++) begin : g_sd2
    always_ff @(posedge clk) begin
      sd2[i+1] <= sd2[i];
    end
  end

  // stage 9: pick weights
  logic               v9;
  logic [31:0]        w9 [2];
  logic signed [15:0] a9 [4];
  logic signed [16:0] b9 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= &wq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (sd2[QUOT_W].near_par) begin
      w9[0] <= {1'b0, ONE_Q30 - sd2[QUOT_W].t30};
      w9[1] <= {1'b0, sd2[QUOT_W].t30};
    end else begin
      w9[0] <= wq[0];
      w9[1] <= wq[1];
    end
    for (int k = 0; k < 4; k++) begin
      a9[k] <= $signed(sd2[QUOT_W].a[k]);
      b9[k] <= $signed(sd2[QUOT_W].b[k]);
    end
  end

  // stage 10: blend products
  logic               v10;
  logic signed [48:0] pa10 [4];
  logic signed [49:0] pb10 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pa10[k] <= $signed({1'b0, w9[0]}) * a9[k];
      pb10[k] <= $signed({1'b0, w9[1]}) * b9[k];
    end
  end

  // stage 11: sum and round to q.26
  logic               v11;
  logic signed [32:0] c11 [4];
  logic signed [50:0] r11 [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r11[k] = 51'(pa10[k]) + 51'(pb10[k]) + 51'sd131072;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      c11[k] <= r11[k][50:18];
    end
  end

  // stage 12: squares
  logic               v12;
  logic [63:0]        sq12 [4];
  logic signed [32:0] c12 [4];
  logic signed [65:0] sqf [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sqf[k] = c11[k] * c11[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else begin
      v12 <= v11;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      sq12[k] <= sqf[k][63:0];
    end
    c12 <= c11;
  end

  // stage 13: sum of squares
  logic        v13;
  logic [63:0] sumsq13;
  cvec_t       sd3 [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else begin
      v13 <= v12;
    end
  end

  always_ff @(posedge clk) begin
    sumsq13 <= sq12[0] + sq12[1] + sq12[2] + sq12[3];
    for (int k = 0; k < 4; k++) begin
      sd3[0][k] <= c12[k];
    end
  end

  logic              r2_v;
  logic [ROOT_W-1:0] r2_q;

  qsn_sqrt u_root_len (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v13),
    .rad       (sumsq13),
    .out_valid (r2_v),
    .root      (r2_q)
  );

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sd3
    always_ff @(posedge clk) begin
      sd3[i+1] <= sd3[i];
    end
  end

  // normalise: rounded |c| * 2^14 / len
  logic [32:0] mag [4];
  logic [47:0] num [4];
  fin_t        sd4 [0:QUOT_W];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = sd3[ROOT_W][k][32] ? (~sd3[ROOT_W][k] + 33'd1) : sd3[ROOT_W][k];
      num[k] = {1'b0, mag[k], 14'b0} + 48'(r2_q[ROOT_W-1:1]);
      sd4[0].neg[k] = sd3[ROOT_W][k][32];
    end
    sd4[0].zero = r2_q == '0;
  end

  logic [3:0]        nv;
  logic [QUOT_W-1:0] nq [4];

  for (genvar k = 0; k < 4; k++) begin : g_ndiv
    qsn_div u_ndiv (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (r2_v),
      .num_hi    ({16'b0, num[k][47:32]}),
      .num_lo    (num[k][31:0]),
      .den       (r2_q),
      .out_valid (nv[k]),
      .quot      (nq[k])
    );
  end

  for (genvar i = 0; i < QUOT_W; i++) begin : g_sd4
    always_ff @(posedge clk) begin
      sd4[i+1] <= sd4[i];
    end
  end

  // output: sign, saturate, zero length
  logic [15:0] o_next [4];
  logic [15:0] oq [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (sd4[QUOT_W].zero) begin
        o_next[k] = '0;
      end else if (!sd4[QUOT_W].neg[k]) begin
        o_next[k] = (nq[k] > 32'd32767) ? 16'h7fff : nq[k][15:0];
      end else begin
        o_next[k] = (nq[k] > 32'd32768) ? 16'h8000 : (~nq[k][15:0] + 16'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= &nv;
    end
  end

  always_ff @(posedge clk) begin
    oq <= o_next;
  end

  assign out_x = $signed(oq[0]);
  assign out_y = $signed(oq[1]);
  assign out_z = $signed(oq[2]);
  assign out_w = $signed(oq[3]);

endmodule

>>> bench/tb_quaternion_slerp_normalized.sv
// self-checking bench for the fixed-point quaternion slerp pipeline
// depends on qsn_pkg and quaternion_slerp_normalized; drives random and corner pairs
module tb_quaternion_slerp_normalized;
  import qsn_pkg::*;

  localparam int LATENCY   = 205;
  localparam int WDOG_LIMIT = 4000;

  typedef struct {
    logic signed [15:0] x, y, z, w;
  } quat_t;

  // arc table of the cordic in q2.30
  function automatic longint arc(int i);
    longint tab [31] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return tab[i];
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(r);
  endfunction

  // arithmetic shift is floor for signed operands
  function automatic longint vec_angle(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < 31; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += arc(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= arc(i);
      end
      x = nx; y = ny;
    end
    if (z < 0) z = 0;
    if (z > 1686629713) z = 1686629713;
    return z;
  endfunction

  function automatic longint rot_sin(longint z);
    longint x, y, nx, ny;
    x = 652032874; y = 0;
    for (int i = 0; i < 31; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= arc(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += arc(i);
      end
      x = nx; y = ny;
    end
    if (y < 0) y = 0;
    if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
    return y;
  endfunction

  function automatic quat_t slerp_unit(quat_t qa, quat_t qb, logic signed [15:0] wt);
    longint a[4], b[4], c[4], t, t30, dotp, sinth, w1, w2, theta, len, q, mag;
    longint unsigned sumsq;
    quat_t r;
    a = '{qa.x, qa.y, qa.z, qa.w};
    b = '{qb.x, qb.y, qb.z, qb.w};
    t = wt;
    if (t < 0) t = 0;
    if (t > 16384) t = 16384;
    t30 = t * 65536;
    dotp = 0;
    for (int k = 0; k < 4; k++) dotp += a[k] * b[k];
    dotp *= 4;
    if (dotp < 0) begin
      dotp = -dotp;
      for (int k = 0; k < 4; k++) b[k] = -b[k];
    end
    if (dotp > (64'sd1 << 30)) dotp = 64'sd1 << 30;
    sinth = isqrt((64'd1 << 60) - longint'(dotp) * longint'(dotp));
    if (sinth < 1074) begin
      w1 = (64'sd1 << 30) - t30; w2 = t30;
    end else begin
      theta = vec_angle(dotp, sinth);
      w1 = (rot_sin((((64'sd1 << 30) - t30) * theta) >> 30) << 30) / sinth;
      w2 = (rot_sin((t30 * theta) >> 30) << 30) / sinth;
    end
    sumsq = 0;
    for (int k = 0; k < 4; k++) begin
      c[k] = (w1 * a[k] + w2 * b[k] + (64'sd1 << 17)) >>> 18;
      sumsq += c[k] * c[k];
    end
    len = isqrt(sumsq);
    for (int k = 0; k < 4; k++) begin
      q = 0;
      if (len != 0) begin
        mag = c[k] < 0 ? -c[k] : c[k];
        q = ((mag << 14) + (len >> 1)) / len;
        if (c[k] < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
      end
      c[k] = q;
    end
    r.x = 16'(c[0]); r.y = 16'(c[1]); r.z = 16'(c[2]); r.w = 16'(c[3]);
    return r;
  endfunction

  class slerp_scoreboard;
    quat_t pending[$];
    int errors = 0;
    int results = 0;

    function void note_transfer(quat_t qa, quat_t qb, logic signed [15:0] wt);
      pending.push_back(slerp_unit(qa, qb, wt));
    endfunction

    function void check_result(quat_t got);
      quat_t exp_q;
      results++;
      if (pending.size() == 0) begin
        $error("result with no transfer outstanding");
        errors++;
        return;
      end
      exp_q = pending.pop_front();
      if (got.x !== exp_q.x) begin $error("out_x exp %0d got %0d", exp_q.x, got.x); errors++; end
      if (got.y !== exp_q.y) begin $error("out_y exp %0d got %0d", exp_q.y, got.y); errors++; end
      if (got.z !== exp_q.z) begin $error("out_z exp %0d got %0d", exp_q.z, got.z); errors++; end
      if (got.w !== exp_q.w) begin $error("out_w exp %0d got %0d", exp_q.w, got.w); errors++; end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0;
  logic busy, done;
  logic signed [15:0] a_x = 0, a_y = 0, a_z = 0, a_w = 0;
  logic signed [15:0] b_x = 0, b_y = 0, b_z = 0, b_w = 0, weight = 0;
  logic signed [15:0] out_x, out_y, out_z, out_w;
  slerp_scoreboard sb = new();
  int idle_cycles = 0;
  int n_sent = 0;

  quaternion_slerp_normalized dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    quat_t qa, qb, got;
    if (!rst && start && !busy) begin
      qa = '{a_x, a_y, a_z, a_w};
      qb = '{b_x, b_y, b_z, b_w};
      sb.note_transfer(qa, qb, weight);
    end
    if (!rst && done) begin
      got = '{out_x, out_y, out_z, out_w};
      sb.check_result(got);
    end
    if (!rst && !(start && !busy) && !done) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("Mismatches found");
      $finish;
    end
  end

  // raises start for one transfer; the caller lowers it after the corners and before each gap
  task automatic send_pair(quat_t qa, quat_t qb, logic signed [15:0] wt);
    a_x <= qa.x; a_y <= qa.y; a_z <= qa.z; a_w <= qa.w;
    b_x <= qb.x; b_y <= qb.y; b_z <= qb.z; b_w <= qb.w;
    weight <= wt;
    start <= 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    n_sent++;
  endtask

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic quat_t rnd_quat();
    quat_t q;
    q = '{rnd16(), rnd16(), rnd16(), rnd16()};
    return q;
  endfunction

  // near-unit quaternion built from a random direction
  function automatic quat_t unit_quat();
    quat_t q;
    real v[4], n;
    n = 0;
    for (int k = 0; k < 4; k++) begin
      v[k] = real'(int'($urandom_range(0, 2000)) - 1000);
      n += v[k] * v[k];
    end
    if (n == 0) begin v[3] = 1; n = 1; end
    n = $sqrt(n);
    q.x = 16'($rtoi(v[0] / n * 16384.0)); q.y = 16'($rtoi(v[1] / n * 16384.0));
    q.z = 16'($rtoi(v[2] / n * 16384.0)); q.w = 16'($rtoi(v[3] / n * 16384.0));
    return q;
  endfunction

  function automatic logic signed [15:0] rnd_weight();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return 16'sd0;
      2: return 16'sd16384;
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  initial begin
    quat_t qa, qb, qz, qi, qn;
    int burst, wait_end, gap;
    qz = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
    qi = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    qn = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // corners: identical and opposite pairs, zero vectors, weight outside 0..1,
    // right angle, full-scale components
    send_pair(qi, qi, 16'sd8192);
    send_pair(qi, qn, 16'sd8192);
    send_pair(qi, qn, -16'sd1);
    send_pair(qz, qz, 16'sd8192);
    send_pair(qi, qz, 16'sd0);
    send_pair(qi, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 16'sh8000);
    send_pair(qi, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 16'sh7fff);
    send_pair(qi, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 16'sd16384);
    send_pair(qi, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 16'sd4096);
    send_pair(qi, '{16'sd0, 16'sd1, 16'sd0, 16'sd16384}, 16'sd8192);
    send_pair('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
              '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 16'sd8192);
    send_pair('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
              '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 16'sd8192);
    send_pair('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff},
              '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}, 16'sd12000);
    send_pair('{-16'sd1, 16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0, 16'sd1},
              16'sd8192);
    start <= 0;

    // wait for the pipeline to drain before the random part
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);

    while (n_sent < 1600) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          qa = rnd_quat(); qb = rnd_quat();
        end else begin
          qa = unit_quat();
          // near-parallel neighbours now and then
          if ($urandom_range(0, 4) == 0) begin
            qb = qa;
            qb.x = qb.x + 16'($urandom_range(0, 2)) - 16'sd1;
          end else begin
            qb = unit_quat();
          end
        end
        send_pair(qa, qb, rnd_weight());
      end
      gap = $urandom_range(0, 1) ? $urandom_range(1, 30) : 0;
      if (gap != 0 || n_sent >= 1600) begin
        start <= 0;
        repeat (gap) @(negedge clk);
      end
    end

    while (sb.pending.size() != 0) @(posedge clk);
    wait_end = 0;
    while (wait_end < LATENCY + 20) begin
      @(posedge clk);
      wait_end++;
    end
    $display("sent %0d quaternion pairs incl. corners, checked %0d results",
             n_sent, sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
